/* hw/rtl/lht_pkg.sv */
// ----------------------------------------------------------------------------
// lht_pkg
// Shared types and constants of the hash table with recency eviction.
// ----------------------------------------------------------------------------
package lht_pkg;

    // request codes
    localparam logic [1:0] MODE_GET    = 2'd0;
    localparam logic [1:0] MODE_PUT    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    // configuration register indexes
    localparam int         CFG_IDX_W      = 2;
    localparam logic [1:0] CFG_LRU_ENABLE = 2'd0;
    localparam logic [1:0] CFG_MAX_COUNT  = 2'd1;
    localparam int         MAX_COUNT_W    = 10;
    localparam logic [MAX_COUNT_W-1:0] MAX_COUNT_RST = 10'd512;

    // integer hash: three xorshift-multiply rounds and a final xorshift
    localparam logic [31:0] MIX_MUL0 = 32'hed5ad4bb;
    localparam logic [31:0] MIX_MUL1 = 32'hac4c1b51;
    localparam logic [31:0] MIX_MUL2 = 32'h31848bab;
    localparam int          MIX_ROUNDS = 4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] key;
        logic [31:0] value;
    } t_request;

    typedef struct packed {
        logic        status;
        logic        found;
        logic [31:0] data;
        logic [31:0] evicted_key;
        logic        is_eviction;
        logic        last;
    } t_result;

    function automatic logic [4:0] mix_shift(input logic [1:0] step);
        logic [4:0] sh;
        case (step)
            2'd0:    sh = 5'd17;
            2'd1:    sh = 5'd11;
            2'd2:    sh = 5'd15;
            default: sh = 5'd14;
        endcase
        return sh;
    endfunction

    function automatic logic [31:0] mix_mult(input logic [1:0] step);
        logic [31:0] m;
        case (step)
            2'd0:    m = MIX_MUL0;
            2'd1:    m = MIX_MUL1;
            default: m = MIX_MUL2;
        endcase
        return m;
    endfunction

endpackage

/* hw/rtl/lht_hash.sv */
// ----------------------------------------------------------------------------
// lht_hash
// Iterative key hash: one shared 32x32 multiplier over three rounds and a
// final xorshift. BUCKETS is a power of two, so the bucket is the low bits.
// ----------------------------------------------------------------------------
module lht_hash #(
    parameter int BUCKETS = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [31:0]                i_key,
    output logic                       o_done,
    output logic [$clog2(BUCKETS)-1:0] o_bucket
);
    import lht_pkg::*;

    localparam int BW = $clog2(BUCKETS);

    typedef enum logic [1:0] {H_IDLE, H_MIX} t_hstate;

    t_hstate         r_state;
    logic [31:0]     r_x;
    logic [4:0]      r_cnt;
    logic            r_done;

    logic [31:0]     mix_in;
    logic [31:0]     mix_prod;

    assign mix_in   = r_x ^ (r_x >> mix_shift(r_cnt[1:0]));
    assign mix_prod = mix_in * mix_mult(r_cnt[1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                H_IDLE: begin
                    if (i_start) begin
                        r_x     <= i_key;
                        r_cnt   <= '0;
                        r_state <= H_MIX;
                    end
                end
                H_MIX: begin
                    // last round is the bare xorshift
                    r_x <= (r_cnt == 5'(MIX_ROUNDS - 1)) ? mix_in : mix_prod;
                    if (r_cnt == 5'(MIX_ROUNDS - 1)) begin
                        r_cnt   <= '0;
                        r_done  <= 1'b1;
                        r_state <= H_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                default: r_state <= H_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_bucket = r_x[BW-1:0];

endmodule

/* hw/rtl/lru_hash_table.sv */
// ----------------------------------------------------------------------------
// lru_hash_table
// A request is hashed, then its bucket is read and compared way by way, and
// a decide step emits the first result; eviction results follow one by one.
// One request at a time: a recency update and each eviction keep the block
// busy after the first result. Clear sweeps all BUCKETS*WAYS slots before its
// result. After reset a clearing pass over all slots runs before the first
// request is taken.
// ----------------------------------------------------------------------------
module lru_hash_table #(
    parameter int BUCKETS           = 64,
    parameter int WAYS              = 8,
    parameter int MAX_EVICT_PER_PUT = 63
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  lht_pkg::t_request                   i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output lht_pkg::t_result                    o_out_item,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lht_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lht_pkg::MAX_COUNT_W-1:0]     i_cfg_data
);
    import lht_pkg::*;

    localparam int NSLOTS = BUCKETS * WAYS;
    localparam int IW     = $clog2(NSLOTS);         // slot address
    localparam int SW     = $clog2(NSLOTS + 1);     // slot or null marker
    localparam int CW     = SW;                     // entry count
    localparam int BW     = $clog2(BUCKETS);
    localparam int WC     = $clog2(WAYS + 1);
    localparam int EW     = $clog2(MAX_EVICT_PER_PUT + 1);
    localparam int KW     = (CW > MAX_COUNT_W) ? CW : MAX_COUNT_W;
    localparam logic [SW-1:0] NIL = SW'(NSLOTS);

    // flag bits per slot
    localparam int FL_VALID = 1;
    localparam int FL_ORDER = 0;

    typedef enum logic [3:0] {
        S_CLR, S_CEMIT, S_IDLE, S_HASH, S_SRD, S_SCMP, S_DECIDE,
        S_TRD, S_TUNL, S_APP1, S_APP2, S_ERD, S_EEMIT
    } t_state;

    // ------------------------------------------------------------------
    // memories: key/value, slot flags, recency links (older, newer)
    // ------------------------------------------------------------------
    logic [63:0]   mem_kv    [NSLOTS];
    logic [1:0]    mem_flag  [NSLOTS];
    logic [SW-1:0] mem_older [NSLOTS];
    logic [SW-1:0] mem_newer [NSLOTS];

    logic [63:0]   q_kv;
    logic [1:0]    q_flag;
    logic [SW-1:0] q_older;
    logic [SW-1:0] q_newer;

    logic          kv_we, fl_we, ol_we, nw_we;
    logic [IW-1:0] kv_wa, fl_wa, ol_wa, nw_wa, rd_addr;
    logic [63:0]   kv_wd;
    logic [1:0]    fl_wd;
    logic [SW-1:0] ol_wd, nw_wd;

    always_ff @(posedge i_clk) begin
        if (kv_we) mem_kv[kv_wa]    <= kv_wd;
        if (fl_we) mem_flag[fl_wa]  <= fl_wd;
        if (ol_we) mem_older[ol_wa] <= ol_wd;
        if (nw_we) mem_newer[nw_wa] <= nw_wd;
        q_kv    <= mem_kv[rd_addr];
        q_flag  <= mem_flag[rd_addr];
        q_older <= mem_older[rd_addr];
        q_newer <= mem_newer[rd_addr];
    end

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    t_state          r_state,   n_state;
    logic            r_lru_en;
    logic [MAX_COUNT_W-1:0] r_max;
    logic [1:0]      r_mode;
    logic [31:0]     r_key,     r_val;
    logic [IW-1:0]   r_base,    n_base;
    logic [WC-1:0]   r_w,       n_w;
    logic [IW-1:0]   r_hit,     n_hit;
    logic            r_hit_ok,  n_hit_ok;
    logic            r_hit_ord, n_hit_ord;
    logic [31:0]     r_hit_val, n_hit_val;
    logic [IW-1:0]   r_free,    n_free;
    logic            r_free_ok, n_free_ok;
    logic [IW-1:0]   r_tgt,     n_tgt;
    logic            r_unl,     n_unl;      // unlink only (remove)
    logic            r_more,    n_more;     // evictions follow the put
    logic [SW-1:0]   r_oldest,  n_oldest;
    logic [SW-1:0]   r_newest,  n_newest;
    logic [CW-1:0]   r_count,   n_count;
    logic [EW-1:0]   r_evn,     n_evn;
    logic [IW-1:0]   r_clr,     n_clr;
    logic            r_clr_req, n_clr_req;  // clear pass answers a request
    logic            r_out_valid, n_out_valid;
    t_result         r_out,     n_out;

    logic            in_acc;
    logic            out_free;
    logic [IW-1:0]   scan_slot;
    logic            key_eq;
    logic [CW-1:0]   cnt_dec;
    logic [CW-1:0]   put_cnt;
    logic            put_more;
    logic            evict_next;
    logic            hash_done;
    logic [BW-1:0]   hash_bucket;

    assign in_acc    = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign scan_slot = r_base + IW'(r_w);
    assign key_eq    = (q_kv[63:32] == r_key);
    assign cnt_dec   = (r_count != '0) ? r_count - CW'(1) : r_count;
    assign put_cnt   = r_hit_ok ? r_count : r_count + CW'(1);
    // the touched entry sits in the order, so the oldest is never null here
    assign put_more  = r_lru_en && (KW'(put_cnt) > KW'(r_max));
    assign evict_next = (q_newer != NIL) && (KW'(cnt_dec) > KW'(r_max))
                        && (int'(r_evn) + 1 < MAX_EVICT_PER_PUT);

    lht_hash #(
        .BUCKETS (BUCKETS)
    ) u_lht_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (in_acc && (i_in_item.mode != MODE_CLEAR)),
        .i_key    (i_in_item.key),
        .o_done   (hash_done),
        .o_bucket (hash_bucket)
    );

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_base      = r_base;
        n_w         = r_w;
        n_hit       = r_hit;
        n_hit_ok    = r_hit_ok;
        n_hit_ord   = r_hit_ord;
        n_hit_val   = r_hit_val;
        n_free      = r_free;
        n_free_ok   = r_free_ok;
        n_tgt       = r_tgt;
        n_unl       = r_unl;
        n_more      = r_more;
        n_oldest    = r_oldest;
        n_newest    = r_newest;
        n_count     = r_count;
        n_evn       = r_evn;
        n_clr       = r_clr;
        n_clr_req   = r_clr_req;
        n_out       = r_out;
        n_out_valid = (r_out_valid && !i_out_ready);

        kv_we = 1'b0; kv_wa = r_hit;  kv_wd = {r_key, r_val};
        fl_we = 1'b0; fl_wa = r_clr;  fl_wd = 2'b00;
        ol_we = 1'b0; ol_wa = r_tgt;  ol_wd = NIL;
        nw_we = 1'b0; nw_wa = r_tgt;  nw_wd = NIL;
        rd_addr = scan_slot;

        unique case (r_state)
            // sweep the flags to empty, one slot a cycle
            S_CLR: begin
                fl_we = 1'b1;
                n_clr = r_clr + IW'(1);
                if (r_clr == IW'(NSLOTS - 1)) begin
                    n_state = r_clr_req ? S_CEMIT : S_IDLE;
                end
            end
            S_CEMIT: begin
                if (out_free) begin
                    n_out       = '0;
                    n_out.last  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_item.mode == MODE_CLEAR) begin
                        n_clr     = '0;
                        n_clr_req = 1'b1;
                        n_oldest  = NIL;
                        n_newest  = NIL;
                        n_count   = '0;
                        n_state   = S_CLR;
                    end else begin
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    n_base    = IW'(hash_bucket) * IW'(WAYS);
                    n_w       = '0;
                    n_hit_ok  = 1'b0;
                    n_free_ok = 1'b0;
                    n_state   = S_SRD;
                end
            end
            S_SRD: begin
                n_state = S_SCMP;
            end
            // first matching way wins, lowest free way is kept
            S_SCMP: begin
                if (q_flag[FL_VALID]) begin
                    if (!r_hit_ok && key_eq) begin
                        n_hit     = scan_slot;
                        n_hit_ok  = 1'b1;
                        n_hit_val = q_kv[31:0];
                        n_hit_ord = q_flag[FL_ORDER];
                    end
                end else if (!r_free_ok) begin
                    n_free    = scan_slot;
                    n_free_ok = 1'b1;
                end
                n_w     = r_w + WC'(1);
                n_state = (r_w == WC'(WAYS - 1)) ? S_DECIDE : S_SRD;
            end
            S_DECIDE: begin
                if (out_free) begin
                    n_out       = '0;
                    n_out_valid = 1'b1;
                    n_out.found = r_hit_ok;
                    n_out.data  = r_hit_ok ? r_hit_val : 32'd0;
                    n_out.last  = 1'b1;
                    n_evn       = '0;
                    n_unl       = 1'b0;
                    n_more      = 1'b0;
                    n_tgt       = r_hit;
                    n_state     = S_IDLE;
                    case (r_mode)
                        MODE_GET: begin
                            if (r_hit_ok && r_lru_en) begin
                                n_state = r_hit_ord ? S_TRD : S_APP1;
                            end
                        end
                        MODE_REMOVE: begin
                            if (r_hit_ok) begin
                                fl_we   = 1'b1;
                                fl_wa   = r_hit;
                                fl_wd   = 2'b00;
                                n_count = cnt_dec;
                                if (r_hit_ord) begin
                                    n_unl   = 1'b1;
                                    n_state = S_TRD;
                                end
                            end
                        end
                        MODE_PUT: begin
                            if (r_hit_ok || r_free_ok) begin
                                kv_we      = 1'b1;
                                kv_wa      = r_hit_ok ? r_hit : r_free;
                                n_tgt      = kv_wa;
                                n_more     = put_more;
                                n_out.last = !put_more;
                                if (!r_hit_ok) begin
                                    fl_we   = 1'b1;
                                    fl_wa   = r_free;
                                    fl_wd   = 2'b10;
                                    n_count = put_cnt;
                                end
                                if (r_lru_en) begin
                                    n_state = (r_hit_ok && r_hit_ord) ? S_TRD : S_APP1;
                                end
                            end else begin
                                // full bucket: reject, table untouched
                                n_out.status = 1'b1;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_TRD: begin
                rd_addr = r_tgt;
                n_state = S_TUNL;
            end
            // unlink: patch both neighbors in this state
            S_TUNL: begin
                if (q_older == NIL) begin
                    n_oldest = q_newer;
                end else begin
                    nw_we = 1'b1;
                    nw_wa = q_older[IW-1:0];
                    nw_wd = q_newer;
                end
                if (q_newer == NIL) begin
                    n_newest = q_older;
                end else begin
                    ol_we = 1'b1;
                    ol_wa = q_newer[IW-1:0];
                    ol_wd = q_older;
                end
                n_state = r_unl ? S_IDLE : S_APP1;
            end
            S_APP1: begin
                ol_we = 1'b1;
                ol_wa = r_tgt;
                ol_wd = r_newest;
                if (r_newest == NIL) begin
                    n_oldest = SW'(r_tgt);
                end else begin
                    nw_we = 1'b1;
                    nw_wa = r_newest[IW-1:0];
                    nw_wd = SW'(r_tgt);
                end
                n_newest = SW'(r_tgt);
                n_state  = S_APP2;
            end
            S_APP2: begin
                nw_we   = 1'b1;
                nw_wa   = r_tgt;
                nw_wd   = NIL;
                fl_we   = 1'b1;
                fl_wa   = r_tgt;
                fl_wd   = 2'b11;
                n_state = r_more ? S_ERD : S_IDLE;
            end
            S_ERD: begin
                rd_addr = r_oldest[IW-1:0];
                n_state = S_EEMIT;
            end
            // evict the oldest entry; its older link is null
            S_EEMIT: begin
                rd_addr = r_oldest[IW-1:0];   // keep the read data while stalled
                if (out_free) begin
                    n_out             = '0;
                    n_out.data        = q_kv[31:0];
                    n_out.evicted_key = q_kv[63:32];
                    n_out.is_eviction = 1'b1;
                    n_out.last        = !evict_next;
                    n_out_valid       = 1'b1;
                    fl_we    = 1'b1;
                    fl_wa    = r_oldest[IW-1:0];
                    fl_wd    = 2'b00;
                    n_oldest = q_newer;
                    if (q_newer == NIL) begin
                        n_newest = NIL;
                    end else begin
                        ol_we = 1'b1;
                        ol_wa = q_newer[IW-1:0];
                        ol_wd = NIL;
                    end
                    n_count = cnt_dec;
                    n_evn   = r_evn + EW'(1);
                    n_state = evict_next ? S_ERD : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_clr_req   <= 1'b0;
            r_oldest    <= NIL;
            r_newest    <= NIL;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_lru_en    <= 1'b0;
            r_max       <= MAX_COUNT_RST;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_clr_req   <= n_clr_req;
            r_oldest    <= n_oldest;
            r_newest    <= n_newest;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_LRU_ENABLE: r_lru_en <= i_cfg_data[0];
                    CFG_MAX_COUNT:  r_max    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_mode <= i_in_item.mode;
                r_key  <= i_in_item.key;
                r_val  <= i_in_item.value;
            end
            r_base    <= n_base;
            r_w       <= n_w;
            r_hit     <= n_hit;
            r_hit_ok  <= n_hit_ok;
            r_hit_ord <= n_hit_ord;
            r_hit_val <= n_hit_val;
            r_free    <= n_free;
            r_free_ok <= n_free_ok;
            r_tgt     <= n_tgt;
            r_unl     <= n_unl;
            r_more    <= n_more;
            r_evn     <= n_evn;
            r_out     <= n_out;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

/* hw/rtl/lht_checker.sv */
// ----------------------------------------------------------------------------
// lht_checker
// Port-level checks on the hash table, bound to the top level.
// ----------------------------------------------------------------------------
module lht_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_ready,
    input lht_pkg::t_request                i_in_item,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input lht_pkg::t_result                 o_out_item,
    input logic                             i_cfg_valid,
    input logic                             o_cfg_ready,
    input logic [lht_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input logic [lht_pkg::MAX_COUNT_W-1:0]  i_cfg_data
);
    import lht_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result item changed while stalled");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while previous one in progress");

    a_evict_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.is_eviction |->
            !o_out_item.status && !o_out_item.found)
        else $error("eviction item carries status or found");

    a_reject_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status |-> o_out_item.last && !o_out_item.found)
        else $error("rejected put is not a single final item");

endmodule

bind lru_hash_table lht_checker u_lht_checker (.*);

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lru_hash_table. A directed table covers misses, hits,
// extremes of key and value, a full bucket, clear and recency eviction. It is
// followed by a fill that forces the eviction cap and by three random phases
// with different idling. Every accepted request runs through a software copy
// of the table, and each result item is compared with the oldest expected one.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lht_pkg::*;

    localparam int NBUCKET  = 64;
    localparam int NWAY     = 8;
    localparam int NSLOT    = NBUCKET * NWAY;
    localparam int EVICT_CAP = 63;
    localparam int NIL      = NSLOT;
    localparam int STALL_LIMIT = 5000;

    typedef enum logic [1:0] {ROW_REQ, ROW_CHK, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind kind;
        t_request  req;
        t_result   first;   // typed expectation, used by ROW_CHK rows
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    t_request               i_in_item = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    t_result                o_out_item;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [MAX_COUNT_W-1:0] i_cfg_data = '0;

    lru_hash_table u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- shadow
    // Software copy of the table: slots, recency list and the two registers.
    logic [31:0] tbl_key [NSLOT];
    logic [31:0] tbl_val [NSLOT];
    bit          tbl_used [NSLOT];
    bit          tbl_listed [NSLOT];
    int          link_old [NSLOT];
    int          link_new [NSLOT];
    int          list_head;   // oldest
    int          list_tail;   // newest
    int          live_count;
    bit          cur_lru = 1'b0;
    int          cur_max = MAX_COUNT_RST;

    t_result     expected_results[$];
    t_result     last_first;   // first result of the latest request
    int          fail_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          recv_hold = 0;

    function automatic logic [31:0] key_hash(logic [31:0] x);
        x = x ^ (x >> 17);
        x = x * MIX_MUL0;
        x = x ^ (x >> 11);
        x = x * MIX_MUL1;
        x = x ^ (x >> 15);
        x = x * MIX_MUL2;
        x = x ^ (x >> 14);
        return x;
    endfunction

    function automatic int bucket_of(logic [31:0] k);
        return int'(key_hash(k) % NBUCKET);
    endfunction

    function automatic void list_remove(int s);
        if (link_old[s] == NIL) list_head = link_new[s];
        else link_new[link_old[s]] = link_new[s];
        if (link_new[s] == NIL) list_tail = link_old[s];
        else link_old[link_new[s]] = link_old[s];
        tbl_listed[s] = 1'b0;
    endfunction

    // move to the newest end of the recency list
    function automatic void list_promote(int s);
        if (tbl_listed[s]) list_remove(s);
        link_old[s] = list_tail;
        link_new[s] = NIL;
        if (list_tail == NIL) list_head = s;
        else link_new[list_tail] = s;
        list_tail = s;
        tbl_listed[s] = 1'b1;
    endfunction

    function automatic void slot_free(int s);
        if (tbl_listed[s]) list_remove(s);
        tbl_used[s] = 1'b0;
        if (live_count > 0) live_count--;
    endfunction

    function automatic t_result mk_result(bit st, bit fd, logic [31:0] d,
                                          logic [31:0] ek, bit ev);
        t_result r;
        r.status = st;
        r.found = fd;
        r.data = d;
        r.evicted_key = ek;
        r.is_eviction = ev;
        r.last = 1'b0;
        return r;
    endfunction

    // Computes the result items of one request, updates the shadow and queues them.
    function automatic void table_apply(t_request rq);
        t_result outs[$];
        int base, hit, freew, s, v;
        base = bucket_of(rq.key) * NWAY;
        hit = NIL;
        freew = NIL;
        if (rq.mode == MODE_CLEAR) begin
            for (int i = 0; i < NSLOT; i++) begin
                tbl_used[i] = 1'b0;
                tbl_listed[i] = 1'b0;
            end
            list_head = NIL;
            list_tail = NIL;
            live_count = 0;
            outs.push_back(mk_result(0, 0, 0, 0, 0));
        end else begin
            for (int w = 0; w < NWAY; w++) begin
                s = base + w;
                if (tbl_used[s]) begin
                    if (hit == NIL && tbl_key[s] == rq.key) hit = s;
                end else if (freew == NIL) begin
                    freew = s;
                end
            end
            if (rq.mode == MODE_GET) begin
                if (hit != NIL) begin
                    if (cur_lru) list_promote(hit);
                    outs.push_back(mk_result(0, 1, tbl_val[hit], 0, 0));
                end else begin
                    outs.push_back(mk_result(0, 0, 0, 0, 0));
                end
            end else if (rq.mode == MODE_REMOVE) begin
                if (hit != NIL) begin
                    outs.push_back(mk_result(0, 1, tbl_val[hit], 0, 0));
                    slot_free(hit);
                end else begin
                    outs.push_back(mk_result(0, 0, 0, 0, 0));
                end
            end else if (hit == NIL && freew == NIL) begin
                // bucket full: reject, nothing changes
                outs.push_back(mk_result(1, 0, 0, 0, 0));
            end else begin
                if (hit != NIL) begin
                    outs.push_back(mk_result(0, 1, tbl_val[hit], 0, 0));
                    s = hit;
                end else begin
                    outs.push_back(mk_result(0, 0, 0, 0, 0));
                    s = freew;
                    tbl_key[s] = rq.key;
                    tbl_used[s] = 1'b1;
                    tbl_listed[s] = 1'b0;
                    live_count++;
                end
                tbl_val[s] = rq.value;
                if (cur_lru) begin
                    list_promote(s);
                    while (list_head != NIL && live_count > cur_max
                           && outs.size() <= EVICT_CAP) begin
                        v = list_head;
                        outs.push_back(mk_result(0, 0, tbl_val[v], tbl_key[v], 1));
                        slot_free(v);
                    end
                end
            end
        end
        outs[outs.size()-1].last = 1'b1;
        last_first = outs[0];
        foreach (outs[i]) expected_results.push_back(outs[i]);
    endfunction

    function automatic void compare_result(t_result e, t_result a);
        if (a.status !== e.status) begin
            $error("status: expected %0h, got %0h", e.status, a.status);
            fail_count++;
        end
        if (a.found !== e.found) begin
            $error("found: expected %0h, got %0h", e.found, a.found);
            fail_count++;
        end
        if (a.data !== e.data) begin
            $error("data: expected %08h, got %08h", e.data, a.data);
            fail_count++;
        end
        if (a.evicted_key !== e.evicted_key) begin
            $error("evicted_key: expected %08h, got %08h", e.evicted_key, a.evicted_key);
            fail_count++;
        end
        if (a.is_eviction !== e.is_eviction) begin
            $error("is_eviction: expected %0h, got %0h", e.is_eviction, a.is_eviction);
            fail_count++;
        end
        if (a.last !== e.last) begin
            $error("last: expected %0h, got %0h", e.last, a.last);
            fail_count++;
        end
    endfunction

    // ---------------------------------------------------------------- driving
    task automatic send_request(t_request rq);
        i_in_valid <= 1'b1;
        i_in_item <= rq;
        do @(posedge i_clk); while (!o_in_ready);
        table_apply(rq);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // only ever called with the block idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [MAX_COUNT_W-1:0] d);
        drain();
        repeat (20) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_LRU_ENABLE) cur_lru = d[0];
        else if (idx == CFG_MAX_COUNT) cur_max = int'(d);
    endtask

    function automatic t_request mk_req(logic [1:0] m, logic [31:0] k, logic [31:0] v);
        t_request r;
        r.mode = m;
        r.key = k;
        r.value = v;
        return r;
    endfunction

    function automatic t_row req_row(logic [1:0] m, logic [31:0] k, logic [31:0] v);
        t_row r;
        r.kind = ROW_REQ;
        r.req = mk_req(m, k, v);
        r.first = '0;
        return r;
    endfunction

    function automatic t_row chk_row(logic [1:0] m, logic [31:0] k, logic [31:0] v,
                                     bit st, bit fd, logic [31:0] d);
        t_row r;
        r = req_row(m, k, v);
        r.kind = ROW_CHK;
        r.first = mk_result(st, fd, d, 0, 0);
        r.first.last = 1'b1;
        return r;
    endfunction

    function automatic t_row cfg_row(logic [1:0] idx, logic [MAX_COUNT_W-1:0] d);
        t_row r;
        r.kind = ROW_CFG;
        r.req = mk_req(idx, 32'(d), 0);
        r.first = '0;
        return r;
    endfunction

    // ------------------------------------------------------------- receiving
    // Ready toggles at random; recv_hold forces a long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (recv_hold > 0) begin
            recv_hold = recv_hold - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result item with nothing expected: %p", o_out_item);
                fail_count++;
            end else begin
                compare_result(expected_results.pop_front(), o_out_item);
            end
        end
    end

    // Watchdog: cycles in a row with no handshake on any channel.
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus
    initial begin
        logic [31:0] same_bkt[$];   // nine keys that share one bucket
        logic [31:0] key_pool[$];
        t_row        rows[$];
        logic [31:0] k, cand;
        int          target, n, r;
        logic [1:0]  m;

        list_head = NIL;
        list_tail = NIL;
        live_count = 0;
        for (int i = 0; i < NSLOT; i++) begin
            tbl_used[i] = 1'b0;
            tbl_listed[i] = 1'b0;
        end

        target = $urandom_range(NBUCKET - 1);
        cand = $urandom;
        while (same_bkt.size() < NWAY + 1) begin
            if (bucket_of(cand) == target) same_bkt.push_back(cand);
            cand++;
        end
        for (int i = 0; i < 40; i++) key_pool.push_back($urandom);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table: typed first results only where they are obvious
        rows.push_back(chk_row(MODE_GET,    32'h0, 32'h0, 0, 0, 0));
        rows.push_back(chk_row(MODE_PUT,    32'h0, 32'hffffffff, 0, 0, 0));
        rows.push_back(chk_row(MODE_GET,    32'h0, 32'h0, 0, 1, 32'hffffffff));
        rows.push_back(chk_row(MODE_PUT,    32'hffffffff, 32'h0, 0, 0, 0));
        rows.push_back(chk_row(MODE_PUT,    32'hffffffff, 32'ha5a55a5a, 0, 1, 32'h0));
        rows.push_back(chk_row(MODE_REMOVE, 32'hffffffff, 32'h0, 0, 1, 32'ha5a55a5a));
        rows.push_back(chk_row(MODE_REMOVE, 32'hffffffff, 32'h0, 0, 0, 0));
        for (int i = 0; i < NWAY; i++)
            rows.push_back(req_row(MODE_PUT, same_bkt[i], $urandom));
        // ninth key into a full bucket is rejected
        rows.push_back(chk_row(MODE_PUT, same_bkt[NWAY], 32'h5a5aa5a5, 1, 0, 0));
        rows.push_back(chk_row(MODE_GET, same_bkt[NWAY], 32'h0, 0, 0, 0));
        rows.push_back(chk_row(MODE_CLEAR, $urandom, $urandom, 0, 0, 0));
        rows.push_back(chk_row(MODE_GET, same_bkt[0], 32'h0, 0, 0, 0));
        // recency eviction with a tiny limit
        rows.push_back(cfg_row(CFG_LRU_ENABLE, 10'd1));
        rows.push_back(cfg_row(CFG_MAX_COUNT, 10'd2));
        rows.push_back(cfg_row(2'd2, 10'h3ff));   // unknown index, ignored
        rows.push_back(req_row(MODE_PUT, same_bkt[0], 32'h11));
        rows.push_back(req_row(MODE_PUT, same_bkt[1], 32'h22));
        rows.push_back(req_row(MODE_GET, same_bkt[0], 0));
        rows.push_back(req_row(MODE_PUT, same_bkt[2], 32'h33));   // evicts key 1
        rows.push_back(req_row(MODE_REMOVE, same_bkt[0], 0));    // unlink from list
        rows.push_back(req_row(MODE_PUT, same_bkt[3], 32'h44));
        rows.push_back(req_row(MODE_CLEAR, 0, 0));

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                write_reg(rows[i].req.mode, rows[i].req.value[MAX_COUNT_W-1:0] |
                          rows[i].req.key[MAX_COUNT_W-1:0]);
            end else begin
                send_request(rows[i].req);
                if (rows[i].kind == ROW_CHK) compare_result(rows[i].first, last_first);
            end
        end

        // Eviction cap: 70 listed entries, then limit 0 and one more put.
        write_reg(CFG_MAX_COUNT, 10'd512);
        for (int i = 0; i < 70; i++) send_request(mk_req(MODE_PUT, $urandom, $urandom));
        write_reg(CFG_MAX_COUNT, 10'd0);
        send_request(mk_req(MODE_PUT, $urandom, $urandom));
        send_request(mk_req(MODE_PUT, $urandom, $urandom));   // drains the rest
        send_request(mk_req(MODE_CLEAR, 0, 0));

        // random phases: setting of the registers and idling differ per phase
        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin
                    write_reg(CFG_LRU_ENABLE, 10'd1);
                    write_reg(CFG_MAX_COUNT, 10'd6);
                    send_idle_pct = 18;
                    recv_idle_pct = 80;
                end
                1: begin
                    write_reg(CFG_LRU_ENABLE, 10'd0);
                    write_reg(CFG_MAX_COUNT, 10'd511);
                    send_idle_pct = 80;
                    recv_idle_pct = 18;
                end
                default: begin
                    write_reg(CFG_LRU_ENABLE, 10'd1);
                    write_reg(CFG_MAX_COUNT, 10'd40);
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int i = 0; i < 60; i++) begin
                // long receiver hold-off while requests keep coming
                if (p == 0 && i == 20) recv_hold = 400;
                r = $urandom_range(99);
                m = (r < 45) ? MODE_PUT : (r < 75) ? MODE_GET :
                    (r < 97) ? MODE_REMOVE : MODE_CLEAR;
                n = $urandom_range(9);
                k = (n < 6) ? key_pool[$urandom_range(key_pool.size() - 1)] :
                    (n < 8) ? same_bkt[$urandom_range(NWAY)] : $urandom;
                send_request(mk_req(m, k, $urandom));
            end
            // sender waits for every expected result before the next phase
            drain();
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/lht_pkg.sv
hw/rtl/lht_hash.sv
hw/rtl/lru_hash_table.sv
hw/rtl/lht_checker.sv
verif/testbench.sv
